// ----- hdl/u8trunc_pkg.sv -----
// Shared types, constants and helpers for the UTF-8 prefix truncator.
`timescale 1ns / 1ps

package u8trunc_pkg;

  // Limit on kept code points after reset
  localparam logic [15:0] MAX_UNITS_RESET = 16'd1024;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Most bytes that one code point can carry
  localparam int GRP_BYTES = 4;

  // Lead byte masks and patterns
  localparam logic [7:0] LEAD2_MASK = 8'he0;
  localparam logic [7:0] LEAD2_PAT  = 8'hc0;
  localparam logic [7:0] LEAD3_MASK = 8'hf0;
  localparam logic [7:0] LEAD3_PAT  = 8'he0;
  localparam logic [7:0] LEAD4_MASK = 8'hf8;
  localparam logic [7:0] LEAD4_PAT  = 8'hf0;
  localparam logic [1:0] CONT_TAG   = 2'b10;

  // One input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  // One output word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_word_t;

  // One queued group: the bytes of a finished code point and/or an end mark
  typedef struct packed {
    logic [GRP_BYTES-1:0][7:0] bytes;
    logic [2:0]                cnt;
    logic                      last;
  } grp_t;

  // Sequence length from a lead byte; zero for a bad lead byte
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
      len = 3'd2;
    end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
      len = 3'd3;
    end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

// ----- hdl/u8trunc_front.sv -----
// Front part: decodes incoming bytes into whole code points and end marks.
`timescale 1ns / 1ps

module u8trunc_front
  import u8trunc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  in_word_t    word,
  input  logic [15:0] max_units,
  output logic        push,
  output grp_t        grp
);

  logic [2:0][7:0] held_r;
  logic [2:0]      seq_len_r, seq_len_nxt;
  logic [1:0]      held_cnt_r, held_cnt_nxt;
  logic [15:0]     unit_cnt_r, unit_cnt_nxt;
  logic            stopped_r, stopped_nxt;
  logic            hb_we;
  logic [1:0]      hb_idx;
  logic [2:0]      len;
  logic [7:0]      b;

  assign b   = word.in_byte;
  assign len = lead_len(b);

  // Decode one accepted word
  always_comb begin
    seq_len_nxt  = seq_len_r;
    held_cnt_nxt = held_cnt_r;
    unit_cnt_nxt = unit_cnt_r;
    stopped_nxt  = stopped_r;
    hb_we        = 1'b0;
    hb_idx       = held_cnt_r;
    grp          = '0;
    push         = 1'b0;
    if (acc) begin
      if (!stopped_r) begin
        if (held_cnt_r == 2'd0) begin
          if (unit_cnt_r >= max_units || len == 3'd0) begin
            stopped_nxt = 1'b1;
          end else if (len == 3'd1) begin
            grp.bytes[0] = b;
            grp.cnt      = 3'd1;
            unit_cnt_nxt = unit_cnt_r + 16'd1;
          end else begin
            hb_we        = 1'b1;
            hb_idx       = 2'd0;
            seq_len_nxt  = len;
            held_cnt_nxt = 2'd1;
          end
        end else if (b[7:6] != CONT_TAG) begin
          // drop the partial sequence
          stopped_nxt  = 1'b1;
          held_cnt_nxt = 2'd0;
          seq_len_nxt  = 3'd0;
        end else if ({1'b0, held_cnt_r} + 3'd1 >= seq_len_r) begin
          // sequence complete: held bytes then this one
          grp.bytes[0] = held_r[0];
          grp.bytes[1] = (held_cnt_r > 2'd1) ? held_r[1] : b;
          grp.bytes[2] = (held_cnt_r > 2'd2) ? held_r[2] : b;
          grp.bytes[3] = b;
          grp.cnt      = {1'b0, held_cnt_r} + 3'd1;
          unit_cnt_nxt = unit_cnt_r + 16'd1;
          held_cnt_nxt = 2'd0;
          seq_len_nxt  = 3'd0;
        end else begin
          hb_we        = 1'b1;
          held_cnt_nxt = held_cnt_r + 2'd1;
        end
      end
      if (word.in_last) begin
        grp.last     = 1'b1;
        seq_len_nxt  = 3'd0;
        held_cnt_nxt = 2'd0;
        unit_cnt_nxt = 16'd0;
        stopped_nxt  = 1'b0;
      end
      push = (grp.cnt != 3'd0) || grp.last;
    end
  end

  // String state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r  <= 3'd0;
      held_cnt_r <= 2'd0;
      unit_cnt_r <= 16'd0;
      stopped_r  <= 1'b0;
    end else begin
      seq_len_r  <= seq_len_nxt;
      held_cnt_r <= held_cnt_nxt;
      unit_cnt_r <= unit_cnt_nxt;
      stopped_r  <= stopped_nxt;
    end
  end

  // Hold bytes of the sequence in progress
  always_ff @(posedge clk) begin
    if (hb_we) begin
      held_r[hb_idx] <= b;
    end
  end

endmodule

// ----- hdl/u8trunc_fifo.sv -----
// Short queue of decoded groups between front and back.
`timescale 1ns / 1ps

module u8trunc_fifo
  import u8trunc_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  grp_t                     wr_grp,
  input  logic                     pop,
  output grp_t                     rd_grp,
  output logic                     full,
  output logic                     empty,
  output logic [$clog2(Depth+1)-1:0] cnt
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  grp_t          mem_r [Depth];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(Depth));
  assign empty   = (cnt_r == '0);
  assign cnt     = cnt_r;
  assign rd_grp  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Depth - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Depth - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_grp;
    end
  end

endmodule

// ----- hdl/u8trunc_back.sv -----
// Back part: unpacks queued groups into output words, one per cycle while out_ready is high.
`timescale 1ns / 1ps

module u8trunc_back
  import u8trunc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  grp_t      q_grp,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  grp_t       cur_r;
  logic [1:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       last_word;
  logic       take;

  // Final word of the current group
  assign last_word = (cur_r.cnt == 3'd0) || ({1'b0, idx_r} == cur_r.cnt - 3'd1);
  assign take      = busy_r && out_ready;
  assign q_pop     = !q_empty && (!busy_r || (take && last_word));

  assign out_valid          = busy_r;
  assign out_data.out_byte  = cur_r.bytes[idx_r];
  assign out_data.out_valid = (cur_r.cnt != 3'd0);
  assign out_data.out_last  = cur_r.last && last_word;

  // Step through the group
  always_comb begin
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (q_pop) begin
      idx_nxt  = 2'd0;
      busy_nxt = 1'b1;
    end else if (take) begin
      if (last_word) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= 2'd0;
      busy_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
    end
  end

  // Load the next group
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_grp;
    end
  end

endmodule

// ----- hdl/utf8_prefix_truncator_core.sv -----
// Top level of the UTF-8 prefix truncator.
//
// Bytes of a string enter on in_valid/in_ready with in_data (byte, last
// flag). Whole UTF-8 code points, up to cfg max_units of them, leave on
// out_valid/out_ready, one byte per word; the final word of a string has
// out_last set, and a string with nothing kept ends in one bare marker word.
// The front decodes one byte per cycle and sends finished code points to a
// queue of FifoDepth groups; the back unpacks them one word per cycle.
// Throughput: one input word per cycle, as long as the queue has room; the
// back emits one word per cycle while out_ready is high, so sustained rate
// is one byte per cycle. A finished code point is written into the queue and
// then loaded into the back's group register before its first word leaves.
// When the receiver stalls, the back holds its word and the queue fills;
// in_ready falls only when the queue is full.
// Reset (rst_n low, synchronous) empties the queue, clears string state and
// sets max_units to 1024. Write cfg_wdata with cfg_we only while idle.
`timescale 1ns / 1ps

module utf8_prefix_truncator_core
  import u8trunc_pkg::*;
#(
  parameter int FifoDepth = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] max_units_r;
  logic        push, q_full, q_empty, q_pop;
  grp_t        wr_grp, rd_grp;
  logic [$clog2(FifoDepth+1)-1:0] q_cnt;

  assign in_ready = !q_full;

  // Limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_units_r <= MAX_UNITS_RESET;
    end else if (cfg_we) begin
      max_units_r <= cfg_wdata;
    end
  end

  u8trunc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_valid && !q_full),
    .word      (in_data),
    .max_units (max_units_r),
    .push      (push),
    .grp       (wr_grp)
  );

  u8trunc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_grp (wr_grp),
    .pop    (q_pop),
    .rd_grp (rd_grp),
    .full   (q_full),
    .empty  (q_empty),
    .cnt    (q_cnt)
  );

  u8trunc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_grp     (rd_grp),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // Never push into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_full)
    else $error("push into full queue");

  // Queue occupancy stays within its depth
  assert property (@(posedge clk) disable iff (!rst_n)
                   q_cnt <= ($clog2(FifoDepth+1))'(FifoDepth))
    else $error("queue count overflow");

  // A word without a byte is always an end marker
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && !out_data.out_valid) |-> out_data.out_last)
    else $error("bare word without last");

  // A pop only happens with data in the queue
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
    else $error("pop from empty queue");
`endif

endmodule
